>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

  // Stored order field, with the marker for a page that starts no block
  localparam int ORD_W = 5;
  localparam logic [ORD_W-1:0] NO_ORDER = '1;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_NO_BLOCK = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_NOT_USED = 3'd5;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_ORD_STEP,
    DP_LVL_STEP,
    DP_TAKE,
    DP_UNLINK,
    DP_SET_J,
    DP_SPLIT_Q,
    DP_PUSH_A,
    DP_PUSH_B,
    DP_INFO_RD,
    DP_FREE_START,
    DP_BUDDY_RD,
    DP_LINK_RD,
    DP_MERGE_A,
    DP_MERGE_B,
    DP_SEL_SELF
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Status flags returned by the datapath
  typedef struct packed {
    logic clr_done;
    logic ord_lt;
    logic ord_big;
    logic lvl_over;
    logic head_hit;
    logic split_more;
    logic q_ok;
    logic pg_bad;
    logic info_bad;
    logic i_top;
    logic merge;
  } dp_sts_t;

  // One entry of the page table
  typedef struct packed {
    logic             used;
    logic [ORD_W-1:0] ord;
  } page_info_t;

endpackage

>>> rtl/bpa_if.sv
`timescale 1ns / 1ps

interface bpa_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] request_bytes;
  logic [9:0]  page_index;

  modport source (output valid, output action, output request_bytes, output page_index,
                  input ready);
  modport sink (input valid, input action, input request_bytes, input page_index,
                output ready);
endinterface

interface bpa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] block_index;
  logic [3:0] block_order;

  modport source (output valid, output status, output block_index, output block_order,
                  input ready);
  modport sink (input valid, input status, input block_index, input block_order,
                output ready);
endinterface

>>> rtl/bpa_dpath.sv
`timescale 1ns / 1ps

module bpa_dpath
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER       = 9,
  parameter int PAGE_COUNT      = 512,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [31:0] in_bytes,
  input  logic [9:0]  in_page,
  output dp_sts_t     sts,
  output logic [8:0]  res_index,
  output logic [3:0]  res_order
);

  localparam int PW  = $clog2(PAGE_COUNT);
  localparam int LW  = PW + 1;
  localparam int NL  = MAX_ORDER + 1;
  localparam int LIX = (NL > 1) ? $clog2(NL) : 1;
  localparam logic [LW-1:0]    NIL     = '1;
  localparam logic [LW-1:0]    PC_L    = LW'(PAGE_COUNT);
  localparam logic [ORD_W-1:0] MAX_O   = ORD_W'(MAX_ORDER);
  localparam logic [32:0]      RND     = 33'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);
  localparam logic [PW-1:0]    CLR_END = PW'(PAGE_COUNT - 1);

  // Page table and list links
  page_info_t      info_mem [PAGE_COUNT];
  logic [LW-1:0]   next_mem [PAGE_COUNT];
  logic [LW-1:0]   prev_mem [PAGE_COUNT];
  page_info_t      info_q;
  logic [LW-1:0]   next_q;
  logic [LW-1:0]   prev_q;

  // List ends per order
  logic [LW-1:0]   head_r [NL];
  logic [LW-1:0]   tail_r [NL];

  logic [PW-1:0]    clr_r;
  logic [32:0]      pages_r;
  logic [ORD_W-1:0] ord_r, lvl_r, i_r;
  logic [PW-1:0]    base_r, aux_r;
  logic             pg_bad_r, bok_r;

  logic [LIX-1:0]   li;
  logic [LW-1:0]    head_i, tail_i;
  logic [31:0]      step, q32, bud32;
  logic             ptr_ok_pv, ptr_ok_nx, ptr_ok_tail;

  logic             info_we;
  logic [PW-1:0]    info_wa, info_ra;
  page_info_t       info_wd;
  logic             next_we, prev_we;
  logic [PW-1:0]    next_wa, prev_wa, link_ra;
  logic [LW-1:0]    next_wd, prev_wd;

  assign li          = i_r[LIX-1:0];
  assign head_i      = head_r[li];
  assign tail_i      = tail_r[li];
  assign step        = 32'd1 << i_r;
  assign q32         = 32'(base_r) + step;
  assign bud32       = 32'(base_r) ^ step;
  assign ptr_ok_pv   = prev_q < PC_L;
  assign ptr_ok_nx   = next_q < PC_L;
  assign ptr_ok_tail = tail_i < PC_L;

  // Status toward the controller
  always_comb begin
    sts.clr_done   = clr_r == CLR_END;
    sts.ord_lt     = (33'd1 << ord_r) < pages_r;
    sts.ord_big    = ord_r > MAX_O;
    sts.lvl_over   = i_r > MAX_O;
    sts.head_hit   = (i_r <= MAX_O) && (head_i < PC_L);
    sts.split_more = i_r < lvl_r;
    sts.q_ok       = q32 < 32'(PAGE_COUNT);
    sts.pg_bad     = pg_bad_r;
    sts.info_bad   = !info_q.used || (info_q.ord > MAX_O);
    sts.i_top      = i_r >= MAX_O;
    sts.merge      = bok_r && (info_q.ord == i_r) && !info_q.used;
  end

  assign res_index = 9'(base_r);
  assign res_order = 4'(ord_r);

  // Memory port selection
  always_comb begin
    info_we = 1'b0;
    info_wa = base_r;
    info_wd = '{used: 1'b0, ord: NO_ORDER};
    info_ra = base_r;
    next_we = 1'b0;
    next_wa = aux_r;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = aux_r;
    prev_wd = tail_i;
    link_ra = aux_r;
    case (cmd.op)
      DP_CLEAR: begin
        info_we = 1'b1;
        info_wa = clr_r;
        info_wd = '{used: 1'b0, ord: (clr_r == '0) ? MAX_O : NO_ORDER};
        next_we = 1'b1;
        next_wa = clr_r;
        next_wd = NIL;
        prev_we = 1'b1;
        prev_wa = clr_r;
        prev_wd = NIL;
      end
      DP_TAKE: begin
        info_we = 1'b1;
        info_wa = head_i[PW-1:0];
        info_wd = '{used: 1'b1, ord: ord_r};
        link_ra = head_i[PW-1:0];
      end
      DP_SPLIT_Q: begin
        info_we = sts.q_ok;
        info_wa = PW'(q32);
        info_wd = '{used: 1'b0, ord: i_r};
      end
      DP_FREE_START: begin
        info_we = 1'b1;
        info_wd = '{used: 1'b0, ord: info_q.ord};
      end
      DP_BUDDY_RD: info_ra = PW'(bud32);
      DP_MERGE_A: begin
        info_we = 1'b1;
        info_wa = (base_r > aux_r) ? aux_r : base_r;
        info_wd = '{used: 1'b0, ord: i_r + ORD_W'(1)};
      end
      DP_MERGE_B: begin
        info_we = 1'b1;
        info_wa = (base_r > aux_r) ? base_r : aux_r;
      end
      DP_UNLINK: begin
        next_we = ptr_ok_pv;
        next_wa = prev_q[PW-1:0];
        next_wd = next_q;
        prev_we = ptr_ok_nx;
        prev_wa = next_q[PW-1:0];
        prev_wd = prev_q;
      end
      DP_PUSH_A: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      DP_PUSH_B: begin
        next_we = ptr_ok_tail;
        next_wa = tail_i[PW-1:0];
        next_wd = LW'(aux_r);
      end
      default: ;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_q <= prev_mem[link_ra];
  end

  // List ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NL; k++) begin
        head_r[k] <= (k == MAX_ORDER) ? '0 : NIL;
        tail_r[k] <= (k == MAX_ORDER) ? '0 : NIL;
      end
    end else if (cmd.op == DP_UNLINK) begin
      if (!ptr_ok_pv) begin
        head_r[li] <= next_q;
      end
      if (!ptr_ok_nx) begin
        tail_r[li] <= prev_q;
      end
    end else if (cmd.op == DP_PUSH_B) begin
      if (!ptr_ok_tail) begin
        head_r[li] <= LW'(aux_r);
      end
      tail_r[li] <= LW'(aux_r);
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == DP_CLEAR && !sts.clr_done) begin
      clr_r <= clr_r + PW'(1);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        pages_r  <= ({1'b0, in_bytes} + RND) >> PAGE_BYTES_LOG2;
        ord_r    <= '0;
        base_r   <= PW'(in_page);
        pg_bad_r <= 32'(in_page) >= 32'(PAGE_COUNT);
      end
      DP_ORD_STEP: begin
        if (sts.ord_lt) begin
          ord_r <= ord_r + ORD_W'(1);
        end
        i_r <= ord_r;
      end
      DP_LVL_STEP: begin
        if (!sts.head_hit) begin
          i_r <= i_r + ORD_W'(1);
        end
      end
      DP_TAKE: begin
        lvl_r  <= i_r;
        base_r <= head_i[PW-1:0];
        aux_r  <= head_i[PW-1:0];
      end
      DP_SET_J: i_r <= ord_r;
      DP_SPLIT_Q: begin
        aux_r <= PW'(q32);
        if (!sts.q_ok) begin
          i_r <= i_r + ORD_W'(1);
        end
      end
      DP_PUSH_B: i_r <= i_r + ORD_W'(1);
      DP_FREE_START: i_r <= info_q.ord;
      DP_BUDDY_RD: begin
        aux_r <= PW'(bud32);
        bok_r <= bud32 < 32'(PAGE_COUNT);
      end
      DP_MERGE_B: begin
        if (base_r > aux_r) begin
          base_r <= aux_r;
        end
        i_r <= i_r + ORD_W'(1);
      end
      DP_SEL_SELF: aux_r <= base_r;
      default: ;
    endcase
  end

endmodule

>>> rtl/bpa_ctrl.sv
`timescale 1ns / 1ps

module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  input  logic       in_zero,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [8:0] out_index,
  output logic [3:0] out_order,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts,
  input  logic [8:0] res_index,
  input  logic [3:0] res_order
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ORD, S_LVL, S_TAKE, S_AUNL, S_J0, S_SPLIT, S_SPA, S_SPB,
    S_FRD, S_FCHK, S_FLOOP, S_FBCHK, S_FUNL, S_MA, S_MB, S_FPA, S_FPB, S_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] code_r, code_nxt;
  logic       alloc_r, alloc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [8:0] out_index_r, out_index_nxt;
  logic [3:0] out_order_r, out_order_nxt;

  assign in_ready   = state_r == S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_order  = out_order_r;

  // Sequence the datapath
  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    alloc_nxt      = alloc_r;
    cmd.op         = DP_NOP;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_order_nxt  = out_order_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          alloc_nxt = 1'b0;
          if (in_action) begin
            state_nxt = S_FRD;
          end else if (in_zero) begin
            code_nxt  = ST_ZERO;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_ORD: begin
        if (sts.ord_big) begin
          code_nxt  = ST_TOO_BIG;
          state_nxt = S_RESULT;
        end else begin
          cmd.op = DP_ORD_STEP;
          if (!sts.ord_lt) state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        if (sts.lvl_over) begin
          code_nxt  = ST_NO_BLOCK;
          state_nxt = S_RESULT;
        end else begin
          cmd.op = DP_LVL_STEP;
          if (sts.head_hit) state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op    = DP_TAKE;
        state_nxt = S_AUNL;
      end
      S_AUNL: begin
        cmd.op    = DP_UNLINK;
        state_nxt = S_J0;
      end
      S_J0: begin
        cmd.op    = DP_SET_J;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.split_more) begin
          cmd.op = DP_SPLIT_Q;
          if (sts.q_ok) state_nxt = S_SPA;
        end else begin
          code_nxt  = ST_OK;
          alloc_nxt = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_SPA: begin
        cmd.op    = DP_PUSH_A;
        state_nxt = S_SPB;
      end
      S_SPB: begin
        cmd.op    = DP_PUSH_B;
        state_nxt = S_SPLIT;
      end
      S_FRD: begin
        if (sts.pg_bad) begin
          code_nxt  = ST_RANGE;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = DP_INFO_RD;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.info_bad) begin
          code_nxt  = ST_NOT_USED;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = DP_FREE_START;
          state_nxt = S_FLOOP;
        end
      end
      S_FLOOP: begin
        if (sts.i_top) begin
          cmd.op    = DP_SEL_SELF;
          state_nxt = S_FPA;
        end else begin
          cmd.op    = DP_BUDDY_RD;
          state_nxt = S_FBCHK;
        end
      end
      S_FBCHK: begin
        if (sts.merge) begin
          cmd.op    = DP_LINK_RD;
          state_nxt = S_FUNL;
        end else begin
          cmd.op    = DP_SEL_SELF;
          state_nxt = S_FPA;
        end
      end
      S_FUNL: begin
        cmd.op    = DP_UNLINK;
        state_nxt = S_MA;
      end
      S_MA: begin
        cmd.op    = DP_MERGE_A;
        state_nxt = S_MB;
      end
      S_MB: begin
        cmd.op    = DP_MERGE_B;
        state_nxt = S_FLOOP;
      end
      S_FPA: begin
        cmd.op    = DP_PUSH_A;
        state_nxt = S_FPB;
      end
      S_FPB: begin
        cmd.op    = DP_PUSH_B;
        code_nxt  = ST_OK;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // Hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = code_r;
          out_index_nxt  = alloc_r ? res_index : 9'd0;
          out_order_nxt  = alloc_r ? res_order : 4'd0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      code_r      <= ST_OK;
      alloc_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
      alloc_r     <= alloc_nxt;
    end
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_order_r  <= out_order_nxt;
  end

endmodule

>>> rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// Channel  Dir  Signals                                        Transaction
// in_ch    in   valid ready action request_bytes page_index    one request
// out_ch   out  valid ready status block_index block_order     one result
//
// One request at a time through a controller and a single-port-write datapath.
// Allocate: order search, list search (one list step a cycle), then splits down to
// the requested order. Free: range and table checks, then buddy merges. Reset is
// synchronous; afterward a sweep initializes the page table and links, during
// which no request is taken. A result waits in the output register; a new request
// is taken meanwhile, and a later result stalls for it.

module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER       = 9,
  parameter int PAGE_COUNT      = 512,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input logic   clk,
  input logic   rst_n,
  bpa_in_if.sink    in_ch,
  bpa_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [8:0] res_index;
  logic [3:0] res_order;

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_action  (in_ch.action),
    .in_zero    (in_ch.request_bytes == 32'd0),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_index  (out_ch.block_index),
    .out_order  (out_ch.block_order),
    .cmd        (cmd),
    .sts        (sts),
    .res_index  (res_index),
    .res_order  (res_order)
  );

  bpa_dpath #(
    .MAX_ORDER       (MAX_ORDER),
    .PAGE_COUNT      (PAGE_COUNT),
    .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_bytes  (in_ch.request_bytes),
    .in_page   (in_ch.page_index),
    .sts       (sts),
    .res_index (res_index),
    .res_order (res_order)
  );

endmodule

>>> rtl/bpa_chk.sv
`timescale 1ns / 1ps

module bpa_chk
  import bpa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [8:0] out_index,
  input logic [3:0] out_order
);

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_index))
    else $error("result changed while stalled");

  // One request in flight: intake closes right after a transaction
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Failed results (status other than OK) carry no block
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_index == 9'd0 && out_order == 4'd0)
    else $error("block fields set on a failed result");

  // Allocated blocks are aligned to their size
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      (out_index & ((9'd1 << out_order) - 9'd1)) == 9'd0)
    else $error("allocated block misaligned");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.block_index),
  .out_order  (out_ch.block_order)
);
